@@ src/lba_to_chs_request_builder_macros.svh @@
// ---------------------------------------------------------------------------
// lba_to_chs_request_builder_macros.svh
// Assertion macros shared by the request builder.
// ---------------------------------------------------------------------------
`ifndef LBA_TO_CHS_REQUEST_BUILDER_MACROS_SVH
`define LBA_TO_CHS_REQUEST_BUILDER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define L2C_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define L2C_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lba2chs_pkg.sv @@
// ---------------------------------------------------------------------------
// lba2chs_pkg
// Widths, register indexes and the pipeline item type of the request builder.
// ---------------------------------------------------------------------------
package lba2chs_pkg;

  localparam int OffW     = 41;
  localparam int LenW     = 32;
  localparam int BlkW     = 32;
  localparam int CntW     = 23;
  localparam int RemW     = 15;
  localparam int HeadW    = 9;
  localparam int SecW     = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 41;
  localparam int CylCells = BlkW;
  localparam int SecCells = RemW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD_COUNT  = 3'd0,
    CFG_SECTORS     = 3'd1,
    CFG_PART_START  = 3'd2,
    CFG_EXT_ENABLE  = 3'd3,
    CFG_DISK_BYTES  = 3'd4
  } cfg_idx_t;

  // One item as it moves along the divider cells
  typedef struct packed {
    logic            vld;
    logic            err;
    logic            wr;
    logic [BlkW-1:0] blk;
    logic [CntW-1:0] cnt;
    logic [BlkW-1:0] cyl;
    logic [BlkW-1:0] num;
    logic [RemW-1:0] rem;
  } pipe_t;

endpackage

@@ src/lba2chs_req_if.sv @@
// ---------------------------------------------------------------------------
// lba2chs_req_if
// Request channel: byte offset, transfer length and opcode.
// ---------------------------------------------------------------------------
interface lba2chs_req_if;
  import lba2chs_pkg::*;

  logic            valid;
  logic            ready;
  logic [OffW-1:0] byte_offset;
  logic [LenW-1:0] transfer_bytes;
  logic            opcode;

  modport source (output valid, byte_offset, transfer_bytes, opcode, input ready);
  modport sink   (input valid, byte_offset, transfer_bytes, opcode, output ready);
endinterface

@@ src/lba2chs_rsp_if.sv @@
// ---------------------------------------------------------------------------
// lba2chs_rsp_if
// Result channel: addressing mode, block number and packed geometry.
// ---------------------------------------------------------------------------
interface lba2chs_rsp_if;
  import lba2chs_pkg::*;

  logic            valid;
  logic            ready;
  logic            range_error;
  logic            packet_mode;
  logic            write_request;
  logic [BlkW-1:0] block_number;
  logic [7:0]      head_number;
  logic [15:0]     cyl_sector_word;
  logic [CntW-1:0] sector_count;

  modport source (output valid, range_error, packet_mode, write_request, block_number,
                  head_number, cyl_sector_word, sector_count, input ready);
  modport sink   (input valid, range_error, packet_mode, write_request, block_number,
                  head_number, cyl_sector_word, sector_count, output ready);
endinterface

@@ src/lba2chs_cfg_if.sv @@
// ---------------------------------------------------------------------------
// lba2chs_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface lba2chs_cfg_if;
  import lba2chs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/lba2chs_cell.sv @@
// ---------------------------------------------------------------------------
// lba2chs_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor if it fits and registers the item.
// ---------------------------------------------------------------------------
module lba2chs_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [lba2chs_pkg::RemW-1:0]  divisor,
  input  lba2chs_pkg::pipe_t            d_in,
  output lba2chs_pkg::pipe_t            d_out
);
  import lba2chs_pkg::*;

  pipe_t       d_r;
  pipe_t       d_nxt;
  logic [RemW:0] trial;
  logic [RemW:0] diff;
  logic          q;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {d_in.rem, d_in.num[BlkW-1]};
    diff  = trial - {1'b0, divisor};
    q     = (trial >= {1'b0, divisor});
    d_nxt = d_in;
    d_nxt.rem = q ? diff[RemW-1:0] : trial[RemW-1:0];
    d_nxt.num = {d_in.num[BlkW-2:0], q};
  end

  // Advance the item by one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (adv) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

@@ src/lba_to_chs_request_builder.sv @@
// ---------------------------------------------------------------------------
// lba_to_chs_request_builder
// Turns disk byte offsets into block numbers and cylinder/head/sector words.
// ---------------------------------------------------------------------------
// Usage:
//   in_req  : request items (byte offset, length, opcode), valid/ready.
//   out_rsp : result items, one per request, valid/ready.
//   cfg_wr  : register writes (index, data); always ready, write only while idle.
// Each accepted request passes one register for the bounds check and
// block sum, 32 cells dividing the block number by the track size, 15
// cells dividing the remainder by sectors per track, and one output
// register. The whole row of division cells advances together, so an
// item can follow every cycle while the receiver takes results, before
// the items ahead of it have left the row.
// When the receiver stalls with a result waiting, the whole row holds and
// in_req.ready drops until the result is taken. Reset empties the row and the
// output register and loads the registers with 16 heads, 63 sectors, no
// partition offset, extended mode off and a disk size of zero.
// ---------------------------------------------------------------------------
`include "lba_to_chs_request_builder_macros.svh"

module lba_to_chs_request_builder (
  input  logic         clk,
  input  logic         rst_n,
  lba2chs_req_if.sink  in_req,
  lba2chs_rsp_if.source out_rsp,
  lba2chs_cfg_if.sink  cfg_wr
);
  import lba2chs_pkg::*;

  logic [HeadW-1:0]    head_count_r;
  logic [SecW-1:0]     sectors_r;
  logic [BlkW-1:0]     part_start_r;
  logic                ext_enable_r;
  logic [CfgDataW-1:0] disk_bytes_r;
  logic [RemW-1:0]     track_r;
  logic [SecW-1:0]     secs_eff_r;
  logic [HeadW-1:0]    heads_eff;
  logic [SecW-1:0]     secs_eff;
  logic [HeadW+SecW-1:0] track_prod;

  logic  adv;
  logic  in_acc;
  pipe_t ent_r;
  pipe_t cyl_chain [0:CylCells];
  pipe_t sec_chain [0:SecCells];
  pipe_t hand;
  pipe_t fin;

  logic            out_vld_r;
  logic            err_r;
  logic            pkt_r;
  logic            wr_r;
  logic [BlkW-1:0] blk_r;
  logic [7:0]      head_r;
  logic [15:0]     cs_r;
  logic [CntW-1:0] cnt_r;
  logic            pkt_nxt;
  logic [SecW-1:0] sec_nxt;

  // Register writes
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r <= HeadW'(16);
      sectors_r    <= SecW'(63);
      part_start_r <= '0;
      ext_enable_r <= 1'b0;
      disk_bytes_r <= '0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_idx_t'(cfg_wr.index))
        CFG_HEAD_COUNT: head_count_r <= cfg_wr.data[HeadW-1:0];
        CFG_SECTORS:    sectors_r    <= cfg_wr.data[SecW-1:0];
        CFG_PART_START: part_start_r <= cfg_wr.data[BlkW-1:0];
        CFG_EXT_ENABLE: ext_enable_r <= cfg_wr.data[0];
        CFG_DISK_BYTES: disk_bytes_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Track size from the geometry, zero counts read as one
  assign heads_eff  = (head_count_r == '0) ? HeadW'(1) : head_count_r;
  assign secs_eff   = (sectors_r == '0) ? SecW'(1) : sectors_r;
  assign track_prod = heads_eff * secs_eff;
  always_ff @(posedge clk) begin
    track_r    <= track_prod[RemW-1:0];
    secs_eff_r <= secs_eff;
  end

  // Whole row advances unless a result is stuck at the output
  assign adv          = !out_vld_r || out_rsp.ready;
  assign in_req.ready = adv;
  assign in_acc       = in_req.valid && adv;

  // Bounds check and block number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else if (adv) begin
      ent_r.vld <= in_acc;
      ent_r.err <= (in_req.byte_offset > disk_bytes_r);
      ent_r.wr  <= in_req.opcode;
      ent_r.blk <= in_req.byte_offset[OffW-1:9] + part_start_r;
      ent_r.cnt <= in_req.transfer_bytes[LenW-1:9];
      ent_r.cyl <= '0;
      ent_r.num <= in_req.byte_offset[OffW-1:9] + part_start_r;
      ent_r.rem <= '0;
    end
  end
  assign cyl_chain[0] = ent_r;

  // Cylinder cells: block number over track size
  for (genvar i = 0; i < CylCells; i++) begin : g_cyl
    lba2chs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor (track_r),
      .d_in    (cyl_chain[i]),
      .d_out   (cyl_chain[i+1])
    );
  end

  // Hand over: keep the cylinder, divide the remainder next
  always_comb begin
    hand     = cyl_chain[CylCells];
    hand.cyl = cyl_chain[CylCells].num;
    hand.num = {cyl_chain[CylCells].rem, (BlkW-RemW)'(0)};
    hand.rem = '0;
  end
  assign sec_chain[0] = hand;

  // Sector cells: remainder over sectors per track
  for (genvar i = 0; i < SecCells; i++) begin : g_sec
    lba2chs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .divisor ({(RemW-SecW)'(0), secs_eff_r}),
      .d_in    (sec_chain[i]),
      .d_out   (sec_chain[i+1])
    );
  end

  // Pick the addressing mode and pack the result
  assign fin     = sec_chain[SecCells];
  assign pkt_nxt = ext_enable_r && (fin.cyl > BlkW'(1023));
  assign sec_nxt = fin.rem[SecW-1:0] + SecW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r  <= fin.err;
      pkt_r  <= !fin.err && pkt_nxt;
      wr_r   <= !fin.err && fin.wr;
      blk_r  <= fin.err ? '0 : fin.blk;
      cnt_r  <= fin.err ? '0 : fin.cnt;
      head_r <= (fin.err || pkt_nxt) ? 8'h00 : fin.num[7:0];
      cs_r   <= (fin.err || pkt_nxt) ? 16'h0000 :
                {fin.cyl[7:0], fin.cyl[9:8], sec_nxt};
    end
  end

  assign out_rsp.valid           = out_vld_r;
  assign out_rsp.range_error     = err_r;
  assign out_rsp.packet_mode     = pkt_r;
  assign out_rsp.write_request   = wr_r;
  assign out_rsp.block_number    = blk_r;
  assign out_rsp.head_number     = head_r;
  assign out_rsp.cyl_sector_word = cs_r;
  assign out_rsp.sector_count    = cnt_r;

  // Error results carry nothing else
  `L2C_ASSERT_NOW(a_err_clean, out_vld_r && err_r, !pkt_r && !wr_r && blk_r == '0 && cnt_r == '0, "range error with data")
  // Packet mode leaves the geometry fields clear
  `L2C_ASSERT_NOW(a_pkt_clean, out_vld_r && pkt_r, head_r == 8'h00 && cs_r == 16'h0000, "packet mode with geometry")
  // Sectors are one-based in geometry mode
  `L2C_ASSERT_NOW(a_sec_base, out_vld_r && !err_r && !pkt_r, cs_r[5:0] != 6'd0, "sector zero in geometry mode")
  // A stalled result holds the row
  `L2C_ASSERT_NEXT(a_stall_hold, out_vld_r && !out_rsp.ready, out_vld_r && $stable(blk_r), "result lost under stall")
endmodule
